>>> design/mvh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvh_pkg
// Types, codes and helper functions shared by the message validator blocks.
// ----------------------------------------------------------------------------
package mvh_pkg;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_OBJECT = 3'd1,
    ST_NAME   = 3'd2,
    ST_VALUE  = 3'd3,
    ST_ACCEPT = 3'd4,
    ST_REJECT = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    VERDICT_BUSY   = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_t;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Control passed from the parser to the hash unit for one transaction.
  typedef struct packed {
    logic fire;   // byte accepted this cycle
    logic last;   // final byte of the message
    logic live;   // parser not yet in reject, byte counts
  } step_ctl_t;

  // Fold whitespace controls to space and upper case to lower case.
  function automatic logic [7:0] norm_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h09 && c <= 8'h0D) begin
      r = CH_SPACE;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Multiply by the FNV prime 0x01000193 as a sum of shifts, mod 2^32.
  function automatic logic [31:0] fnv_mul(input logic [31:0] x);
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

>>> design/mvh_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvh_parse
// Byte normalizer and six-state flat-object syntax automaton.
// ----------------------------------------------------------------------------
module mvh_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   last,
  input  logic [7:0]             char_in,
  output logic [7:0]             norm,
  output mvh_pkg::step_ctl_t     ctl,
  output mvh_pkg::parse_state_t  state,
  output mvh_pkg::parse_state_t  state_after
);

  mvh_pkg::parse_state_t state_next;
  mvh_pkg::parse_state_t step;

  assign norm = mvh_pkg::norm_byte(char_in);

  always_comb begin
    step = mvh_pkg::ST_REJECT;
    case (state)
      mvh_pkg::ST_INIT: begin
        if (norm == mvh_pkg::CH_SPACE) step = mvh_pkg::ST_INIT;
        else if (norm == mvh_pkg::CH_LBRACE) step = mvh_pkg::ST_OBJECT;
      end
      mvh_pkg::ST_OBJECT: begin
        if (norm == mvh_pkg::CH_SPACE) step = mvh_pkg::ST_OBJECT;
        else if (norm == mvh_pkg::CH_QUOTE) step = mvh_pkg::ST_NAME;
        else if (norm == mvh_pkg::CH_RBRACE) step = mvh_pkg::ST_ACCEPT;
      end
      mvh_pkg::ST_NAME: begin
        if ((norm >= 8'h61 && norm <= 8'h7A) || (norm >= 8'h30 && norm <= 8'h39) ||
            norm == mvh_pkg::CH_UNDERLINE) step = mvh_pkg::ST_NAME;
        else if (norm == mvh_pkg::CH_QUOTE) step = mvh_pkg::ST_VALUE;
      end
      mvh_pkg::ST_VALUE: begin
        if (norm == mvh_pkg::CH_COMMA) step = mvh_pkg::ST_OBJECT;
        else if (norm == mvh_pkg::CH_RBRACE) step = mvh_pkg::ST_ACCEPT;
        else if (norm >= 8'h20 && norm <= 8'h7E && norm != mvh_pkg::CH_BACKSLASH)
          step = mvh_pkg::ST_VALUE;
      end
      default: step = mvh_pkg::ST_REJECT;
    endcase
  end

  // Once in reject, hold there until the final byte.
  assign state_after = (state == mvh_pkg::ST_REJECT) ? mvh_pkg::ST_REJECT : step;

  assign ctl.fire = fire;
  assign ctl.last = last;
  assign ctl.live = (state != mvh_pkg::ST_REJECT);

  always_comb begin
    state_next = state;
    if (fire) begin
      state_next = last ? mvh_pkg::ST_INIT : state_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvh_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> design/mvh_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvh_hash
// FNV-1a 32-bit hash over the first HASH_LIMIT normalized bytes.
// ----------------------------------------------------------------------------
module mvh_hash #(
  parameter int HASH_LIMIT = 4095
) (
  input  logic               clk,
  input  logic               rst,
  input  mvh_pkg::step_ctl_t ctl,
  input  logic [7:0]         norm,
  output logic [31:0]        hash_after
);

  localparam int CW = $clog2(HASH_LIMIT + 1);

  logic [31:0]   hash;
  logic [31:0]   hash_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          take;

  assign take       = ctl.live && (count < CW'(HASH_LIMIT));
  assign hash_after = take ? mvh_pkg::fnv_mul(hash ^ {24'd0, norm}) : hash;

  always_comb begin
    hash_next  = hash;
    count_next = count;
    if (ctl.fire) begin
      if (ctl.last) begin
        hash_next  = mvh_pkg::FNV_BASIS;
        count_next = '0;
      end else begin
        hash_next  = hash_after;
        count_next = take ? count + 1'b1 : count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash  <= mvh_pkg::FNV_BASIS;
      count <= '0;
    end else begin
      hash  <= hash_next;
      count <= count_next;
    end
  end

endmodule

>>> design/message_validator_with_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_validator_with_hash_top
// Byte-stream flat-object validator with an FNV-1a hash of the message.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one message byte per transaction in s_tdata,
//   s_tlast high on the final byte of the message.
//   Master channel (m_*): one result per accepted byte. m_tdata carries
//   the verdict (busy/accept/reject), the automaton position after the
//   byte and the hash; m_tlast echoes the final-byte marker.
//   The verdict is nonzero only on the final byte; the hash is nonzero
//   only on an accepted final byte.
// Timing: the result is registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle while s_tready is high. The parser state and hash registers
//   update in the accepting cycle; the hash step is a combinational
//   shift-add multiply by the FNV prime.
// Stall: the single output register holds its result while m_tready is
//   low; s_tready is high whenever that register is empty or being taken.
// Reset: rst (synchronous) clears the output valid, returns the parser to
//   init and the hash to the offset basis. After each final byte the parser
//   init state and the hash basis are restored for the next message.
// ----------------------------------------------------------------------------
module message_validator_with_hash_top #(
  parameter int HASH_LIMIT = 4095
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] verdict, [4:2] parse_position,
                                 // [36:5] hash_value, [39:37] zero
  output logic        m_tlast    // message_done
);

  logic                  s_fire;
  logic [7:0]            norm;
  mvh_pkg::step_ctl_t    ctl;
  mvh_pkg::parse_state_t state;
  mvh_pkg::parse_state_t state_after;
  logic [31:0]           hash_after;

  logic                  out_valid;
  logic                  out_valid_next;
  logic [1:0]            verdict;
  logic [2:0]            position;
  logic [31:0]           hash_out;
  logic                  done;

  // Accept whenever the output register is free or draining this cycle.
  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  mvh_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .fire        (s_fire),
    .last        (s_tlast),
    .char_in     (s_tdata),
    .norm        (norm),
    .ctl         (ctl),
    .state       (state),
    .state_after (state_after)
  );

  mvh_hash #(
    .HASH_LIMIT (HASH_LIMIT)
  ) u_hash (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .norm       (norm),
    .hash_after (hash_after)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (s_fire) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Capture the result payload on each accepted byte.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      position <= state_after;
      done     <= s_tlast;
      if (!s_tlast) begin
        verdict  <= mvh_pkg::VERDICT_BUSY;
        hash_out <= '0;
      end else if (state_after == mvh_pkg::ST_ACCEPT) begin
        verdict  <= mvh_pkg::VERDICT_ACCEPT;
        hash_out <= hash_after;
      end else begin
        verdict  <= mvh_pkg::VERDICT_REJECT;
        hash_out <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, hash_out, position, verdict};
  assign m_tlast  = done;

  // A verdict appears exactly on the final result of a message.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[1:0] != mvh_pkg::VERDICT_BUSY) == m_tlast))
    else $error("verdict does not match final-byte marker");

  // Accept verdict only with the automaton standing in accept.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == mvh_pkg::VERDICT_ACCEPT |-> m_tdata[4:2] == mvh_pkg::ST_ACCEPT)
    else $error("accept verdict without accept state");

  // Hash is shown only on accepted messages.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != mvh_pkg::VERDICT_ACCEPT |-> m_tdata[36:5] == 32'd0)
    else $error("hash shown on a result that is not accepted");

  // The parser returns to init after the final byte.
  assert property (@(posedge clk) disable iff (rst)
    s_fire && s_tlast |=> state == mvh_pkg::ST_INIT)
    else $error("parser not back at init after final byte");

endmodule
